### rtl/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  // Bound on the reduced numerator and denominator
  localparam int unsigned RAU_WIDTH = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } rau_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIV0    = 2'd1,
    ST_OVF     = 2'd2,
    ST_BAD_DEN = 2'd3
  } rau_status_e;

  // Classified item handed from the front to the back
  typedef struct packed {
    rau_op_e     op;
    logic        l_neg;
    logic [31:0] l_num;
    logic [31:0] l_den;
    logic        r_neg;
    logic [31:0] r_num;
    logic [31:0] r_den;
    rau_status_e status;
  } rau_item_t;

endpackage

### rtl/rau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_front
// Input stage: takes one item, flags bad denominators and division by zero.
// ----------------------------------------------------------------------------
module rau_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic              left_negative_i,
  input  logic [31:0]       left_numerator_i,
  input  logic [31:0]       left_denominator_i,
  input  logic              right_negative_i,
  input  logic [31:0]       right_numerator_i,
  input  logic [31:0]       right_denominator_i,
  output logic              push_o,
  output rau_pkg::rau_item_t item_o,
  input  logic              full_i
);
  import rau_pkg::*;

  logic      vld_q, vld_d;
  rau_item_t item_q, item_d;
  logic      take;

  assign in_stall_o = vld_q && full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign push_o     = vld_q && !full_i;
  assign item_o     = item_q;

  // Classify the incoming transfer
  always_comb begin
    item_d        = item_q;
    item_d.op     = rau_op_e'(opcode_i);
    item_d.l_neg  = left_negative_i;
    item_d.l_num  = left_numerator_i;
    item_d.l_den  = left_denominator_i;
    item_d.r_neg  = right_negative_i;
    item_d.r_num  = right_numerator_i;
    item_d.r_den  = right_denominator_i;
    if (left_denominator_i == '0 || right_denominator_i == '0) begin
      item_d.status = ST_BAD_DEN;
    end else if (rau_op_e'(opcode_i) == OP_DIV && right_numerator_i == '0) begin
      item_d.status = ST_DIV0;
    end else begin
      item_d.status = ST_OK;
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (push_o) vld_d = 1'b0;
    if (take)   vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Hold the item until the queue takes it
  always_ff @(posedge clk_i) begin
    if (take) item_q <= item_d;
  end

endmodule

### rtl/rau_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_fifo
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module rau_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rau_pkg::rau_item_t din_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output rau_pkg::rau_item_t dout_o
);
  import rau_pkg::*;

  rau_item_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign dout_o  = mem_q[rd_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= din_i;
  end

endmodule

### rtl/rau_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_div
// Restoring divider, 65-bit dividend by 64-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module rau_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [64:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [64:0] quotient_o
);
  localparam logic [6:0] Steps = 7'd65;

  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [63:0] rem_q, dvs_q;
  logic [64:0] quo_q;
  logic [64:0] shifted, diff;
  logic        qbit;

  // One restoring step
  always_comb begin
    shifted = {rem_q, quo_q[64]};
    diff    = shifted - {1'b0, dvs_q};
    qbit    = shifted >= {1'b0, dvs_q};
  end

  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == Steps - 7'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[63:0] : shifted[63:0];
      quo_q <= {quo_q[63:0], qbit};
    end
  end

endmodule

### rtl/rau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_back
// Execution sequencer: binary GCD, shared multiplier and divider, reduction.
// ----------------------------------------------------------------------------
module rau_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  rau_pkg::rau_item_t item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               result_negative_o,
  output logic [31:0]        result_numerator_o,
  output logic [31:0]        result_denominator_o,
  output logic [1:0]         status_o
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_GCD1, S_DIV_A, S_DIV_B, S_MUL_NL, S_MUL_NR, S_MUL_DEN, S_SUM,
    S_MUL_N, S_MUL_D, S_ZCHK, S_GCD2, S_DIV_N, S_DIV_D, S_CHK, S_DONE
  } state_e;

  state_e      state_q;
  rau_item_t   it_q;
  rau_status_e stat_q;
  logic        sign_q;
  logic [64:0] num_q, u_q, v_q;
  logic [63:0] den_q, g_q, nl_q, nr_q;
  logic [31:0] a_q, b_q;
  logic [6:0]  k_q;
  logic        div_run_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [64:0] div_dvd, div_q;
  logic [63:0] div_dvs;
  logic        div_start, div_done, div_state;
  logic        gcd_end;
  logic [64:0] gcd_g;
  logic [64:0] u_d, v_d;
  logic [6:0]  k_d;
  logic        r_eff;

  // Shared multiplier operands
  always_comb begin
    mul_a = it_q.l_num;
    mul_b = it_q.r_num;
    case (state_q)
      S_MUL_N: begin
        mul_a = it_q.l_num;
        mul_b = (it_q.op == OP_MUL) ? it_q.r_num : it_q.r_den;
      end
      S_MUL_D: begin
        mul_a = it_q.l_den;
        mul_b = (it_q.op == OP_MUL) ? it_q.r_den : it_q.r_num;
      end
      S_MUL_NL: begin
        mul_a = it_q.l_num;
        mul_b = b_q;
      end
      S_MUL_NR: begin
        mul_a = it_q.r_num;
        mul_b = a_q;
      end
      S_MUL_DEN: begin
        mul_a = a_q;
        mul_b = it_q.r_den;
      end
      default: ;
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Shared divider operands
  always_comb begin
    div_dvd = {33'd0, it_q.l_den};
    case (state_q)
      S_DIV_B: div_dvd = {33'd0, it_q.r_den};
      S_DIV_N: div_dvd = num_q;
      S_DIV_D: div_dvd = {1'b0, den_q};
      default: ;
    endcase
  end
  assign div_dvs   = g_q;
  assign div_state = state_q == S_DIV_A || state_q == S_DIV_B ||
                     state_q == S_DIV_N || state_q == S_DIV_D;
  assign div_start = div_state && !div_run_q;

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // One binary GCD step
  always_comb begin
    u_d     = u_q;
    v_d     = v_q;
    k_d     = k_q;
    gcd_end = u_q == '0 || v_q == '0;
    gcd_g   = (u_q | v_q) << k_q;
    if (!u_q[0] && !v_q[0]) begin
      u_d = u_q >> 1;
      v_d = v_q >> 1;
      k_d = k_q + 7'd1;
    end else if (!u_q[0]) begin
      u_d = u_q >> 1;
    end else if (!v_q[0]) begin
      v_d = v_q >> 1;
    end else if (u_q >= v_q) begin
      u_d = (u_q - v_q) >> 1;
    end else begin
      v_d = (v_q - u_q) >> 1;
    end
  end

  assign pop_o = state_q == S_IDLE && !empty_i;
  assign r_eff = it_q.r_neg ^ (it_q.op == OP_SUB);

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_run_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (div_start) div_run_q <= 1'b1;
      else if (div_done) div_run_q <= 1'b0;
      // Raise the result when loaded, drop it once transferred
      if (state_q == S_DONE && (!out_valid_o || !out_stall_i)) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            if (item_i.status != ST_OK)                          state_q <= S_DONE;
            else if (item_i.op == OP_MUL || item_i.op == OP_DIV) state_q <= S_MUL_N;
            else                                                 state_q <= S_GCD1;
          end
        end
        S_GCD1:    if (gcd_end) state_q <= S_DIV_A;
        S_DIV_A:   if (div_done) state_q <= S_DIV_B;
        S_DIV_B:   if (div_done) state_q <= S_MUL_NL;
        S_MUL_NL:  state_q <= S_MUL_NR;
        S_MUL_NR:  state_q <= S_MUL_DEN;
        S_MUL_DEN: state_q <= S_SUM;
        S_SUM:     state_q <= S_ZCHK;
        S_MUL_N:   state_q <= S_MUL_D;
        S_MUL_D:   state_q <= S_ZCHK;
        S_ZCHK:    state_q <= (num_q == '0) ? S_DONE : S_GCD2;
        S_GCD2:    if (gcd_end) state_q <= S_DIV_N;
        S_DIV_N:   if (div_done) state_q <= S_DIV_D;
        S_DIV_D:   if (div_done) state_q <= S_CHK;
        S_CHK:     state_q <= S_DONE;
        S_DONE: begin
          if (!out_valid_o || !out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        it_q   <= item_i;
        stat_q <= item_i.status;
        sign_q <= 1'b0;
        u_q    <= {33'd0, item_i.l_den};
        v_q    <= {33'd0, item_i.r_den};
        k_q    <= '0;
      end
      S_GCD1, S_GCD2: begin
        u_q <= u_d;
        v_q <= v_d;
        k_q <= k_d;
        if (gcd_end) g_q <= gcd_g[63:0];
      end
      S_DIV_A:   if (div_done) a_q <= div_q[31:0];
      S_DIV_B:   if (div_done) b_q <= div_q[31:0];
      S_MUL_NL:  nl_q <= mul_p;
      S_MUL_NR:  nr_q <= mul_p;
      S_MUL_DEN: den_q <= mul_p;
      S_MUL_N: begin
        num_q  <= {1'b0, mul_p};
        sign_q <= it_q.l_neg ^ it_q.r_neg;
      end
      S_MUL_D:   den_q <= mul_p;
      S_SUM: begin
        if (it_q.l_neg == r_eff) begin
          num_q  <= {1'b0, nl_q} + {1'b0, nr_q};
          sign_q <= it_q.l_neg;
        end else if (nl_q >= nr_q) begin
          num_q  <= {1'b0, nl_q - nr_q};
          sign_q <= it_q.l_neg;
        end else begin
          num_q  <= {1'b0, nr_q - nl_q};
          sign_q <= r_eff;
        end
      end
      S_ZCHK: begin
        u_q <= num_q;
        v_q <= {1'b0, den_q};
        k_q <= '0;
        if (num_q == '0) den_q <= 64'd1;
      end
      S_DIV_N:   if (div_done) num_q <= div_q;
      S_DIV_D:   if (div_done) den_q <= div_q[63:0];
      S_CHK: begin
        if (|num_q[64:RAU_WIDTH] || |den_q[63:RAU_WIDTH]) stat_q <= ST_OVF;
      end
      S_DONE: begin
        if (!out_valid_o || !out_stall_i) begin
          status_o <= stat_q;
          if (stat_q != ST_OK) begin
            result_negative_o    <= 1'b0;
            result_numerator_o   <= '0;
            result_denominator_o <= 32'd1;
          end else begin
            result_negative_o    <= sign_q;
            result_numerator_o   <= num_q[31:0];
            result_denominator_o <= den_q[31:0];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact sign-magnitude fraction add, subtract, multiply and divide, reduced
// to lowest terms.
// ----------------------------------------------------------------------------
// One item at a time is computed in the back end; the front stage and a
// two-entry queue take further items meanwhile. Latency depends on the
// operation and operands: an item with a bad denominator or a zero divisor
// goes straight to the result; a product or quotient takes two multiplies
// and, unless the result is zero, one binary GCD and two divisions; a sum
// or difference adds a GCD of the denominators and two more divisions. The
// shared bit-serial divider and the one-step-per-cycle GCD dominate it.
module rational_arithmetic_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic        left_negative_i,
  input  logic [31:0] left_numerator_i,
  input  logic [31:0] left_denominator_i,
  input  logic        right_negative_i,
  input  logic [31:0] right_numerator_i,
  input  logic [31:0] right_denominator_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_negative_o,
  output logic [31:0] result_numerator_o,
  output logic [31:0] result_denominator_o,
  output logic [1:0]  status_o
);
  import rau_pkg::*;

  logic      push, full, pop, empty;
  rau_item_t front_item, queue_item;

  rau_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .opcode_i            (opcode_i),
    .left_negative_i     (left_negative_i),
    .left_numerator_i    (left_numerator_i),
    .left_denominator_i  (left_denominator_i),
    .right_negative_i    (right_negative_i),
    .right_numerator_i   (right_numerator_i),
    .right_denominator_i (right_denominator_i),
    .push_o              (push),
    .item_o              (front_item),
    .full_i              (full)
  );

  rau_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .dout_o  (queue_item)
  );

  rau_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .empty_i              (empty),
    .item_i               (queue_item),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .result_negative_o    (result_negative_o),
    .result_numerator_o   (result_numerator_o),
    .result_denominator_o (result_denominator_o),
    .status_o             (status_o)
  );

endmodule

### sim/rational_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb
// Drives operand pairs through the fraction unit under random input gaps and
// output stalls, predicts each reduced fraction and status, and compares
// every result transfer field by field in order of arrival.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned CYCLE_LIMIT  = 20_000_000;
  localparam int unsigned DRAIN_CYCLES = 600;

  typedef struct {
    rau_op_e     op;
    logic        l_neg;
    logic [31:0] l_num;
    logic [31:0] l_den;
    logic        r_neg;
    logic [31:0] r_num;
    logic [31:0] r_den;
  } operands_t;

  typedef struct {
    logic        neg;
    logic [31:0] num;
    logic [31:0] den;
    rau_status_e status;
  } fraction_t;

  // Predicted fractions, oldest first
  class fraction_scoreboard;
    fraction_t pending[$];

    function automatic logic [64:0] gcd65(logic [64:0] a, logic [64:0] b);
      logic [64:0] t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    // Work out the reduced fraction for one accepted operand pair
    function void note_operands(operands_t o);
      fraction_t   f;
      logic [64:0] num, den, g, a, b, nl, nr, lim;
      logic        rse;
      num = 0;
      den = 1;
      f.neg = 0;
      f.num = 0;
      f.den = 1;
      f.status = ST_OK;
      lim = (65'd1 << RAU_WIDTH) - 65'd1;
      if (o.l_den == 0 || o.r_den == 0) begin
        f.status = ST_BAD_DEN;
      end else if (o.op == OP_DIV && o.r_num == 0) begin
        f.status = ST_DIV0;
      end else if (o.op == OP_MUL) begin
        num = 65'(o.l_num) * 65'(o.r_num);
        den = 65'(o.l_den) * 65'(o.r_den);
        f.neg = o.l_neg ^ o.r_neg;
      end else if (o.op == OP_DIV) begin
        num = 65'(o.l_num) * 65'(o.r_den);
        den = 65'(o.l_den) * 65'(o.r_num);
        f.neg = o.l_neg ^ o.r_neg;
      end else begin
        // Align over the least common multiple of the denominators
        g = gcd65(65'(o.l_den), 65'(o.r_den));
        a = 65'(o.l_den) / g;
        b = 65'(o.r_den) / g;
        nl = 65'(o.l_num) * b;
        nr = 65'(o.r_num) * a;
        rse = o.r_neg ^ (o.op == OP_SUB);
        den = a * 65'(o.r_den);
        if (o.l_neg == rse) begin
          num = nl + nr;
          f.neg = o.l_neg;
        end else if (nl >= nr) begin
          num = nl - nr;
          f.neg = o.l_neg;
        end else begin
          num = nr - nl;
          f.neg = rse;
        end
      end
      if (f.status == ST_OK && num != 0) begin
        g = gcd65(num, den);
        num = num / g;
        den = den / g;
        if (num > lim || den > lim) f.status = ST_OVF;
        else begin
          f.num = num[31:0];
          f.den = den[31:0];
        end
      end
      if (f.status != ST_OK) begin
        f.neg = 0;
        f.num = 0;
        f.den = 1;
      end
      pending.insert(pending.size(), f);
    endfunction

    // Compare one result with the oldest prediction; empty string means match
    function string match_result(fraction_t got);
      fraction_t w;
      if (pending.size() == 0) return "result with nothing predicted";
      w = pending.pop_front();
      if (got.status != w.status || got.neg != w.neg || got.num != w.num
          || got.den != w.den)
        return $sformatf("got st=%0d %s%0d/%0d, want st=%0d %s%0d/%0d",
                         got.status, got.neg ? "-" : "+", got.num, got.den,
                         w.status, w.neg ? "-" : "+", w.num, w.den);
      return "";
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = '0;
  logic        left_negative_i = 0;
  logic [31:0] left_numerator_i = '0;
  logic [31:0] left_denominator_i = '0;
  logic        right_negative_i = 0;
  logic [31:0] right_numerator_i = '0;
  logic [31:0] right_denominator_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1;
  logic        result_negative_o;
  logic [31:0] result_numerator_o;
  logic [31:0] result_denominator_o;
  logic [1:0]  status_o;

  rational_arithmetic_unit u_dut (.*);

  fraction_scoreboard sb = new();
  int unsigned mismatches = 0;
  int unsigned accepted = 0;
  int unsigned cycles = 0;
  bit          burst_free = 0;

  always #1 clk_i = ~clk_i;

  task automatic report(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // Check each result transfer
  always @(posedge clk_i) begin
    fraction_t got;
    string     msg;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.neg = result_negative_o;
      got.num = result_numerator_o;
      got.den = result_denominator_o;
      got.status = rau_status_e'(status_o);
      msg = sb.match_result(got);
      if (msg != "") report(msg);
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Stall the result side; hold off once for a long stretch to fill the block
  initial begin
    bit held;
    int unsigned mode;
    held = 0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        @(negedge clk_i);
        if (!held && accepted >= 300) begin
          held = 1;
          out_stall_i <= 1;
          repeat (3000) @(negedge clk_i);
        end
        case (mode)
          0: out_stall_i <= 0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Offer one item and hold it until the transfer
  task automatic send(operands_t o);
    @(negedge clk_i);
    in_valid_i          <= 1;
    opcode_i            <= o.op;
    left_negative_i     <= o.l_neg;
    left_numerator_i    <= o.l_num;
    left_denominator_i  <= o.l_den;
    right_negative_i    <= o.r_neg;
    right_numerator_i   <= o.r_num;
    right_denominator_i <= o.r_den;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_operands(o);
    accepted++;
  endtask

  task automatic idle_gap();
    if (burst_free) return;
    repeat ($urandom_range(1, 12)) begin
      @(negedge clk_i);
      in_valid_i <= 0;
    end
  endtask

  function automatic logic [31:0] rand_mag(bit nonzero);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1, 2: v = $urandom_range(1, 15);
      3, 4, 5: v = $urandom_range(1, 1000);
      6: v = $urandom_range(1, 65535);
      7: v = 32'hFFFF_FFFF;
      default: v = $urandom;
    endcase
    if (nonzero && v == 0 && $urandom_range(0, 15) != 0) v = 1;
    return v;
  endfunction

  function automatic operands_t mk(rau_op_e op, logic ln, logic [31:0] lnum,
                                   logic [31:0] lden, logic rn, logic [31:0] rnum,
                                   logic [31:0] rden);
    operands_t o;
    o.op = op; o.l_neg = ln; o.l_num = lnum; o.l_den = lden;
    o.r_neg = rn; o.r_num = rnum; o.r_den = rden;
    return o;
  endfunction

  initial begin
    operands_t   o;
    operands_t   directed[$];
    int unsigned waited;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // Directed corners
    directed.insert(directed.size(), mk(OP_ADD, 0, 1, 2, 0, 1, 3));
    directed.insert(directed.size(), mk(OP_SUB, 0, 1, 2, 0, 1, 2));
    directed.insert(directed.size(), mk(OP_SUB, 1, 1, 2, 1, 1, 2));
    directed.insert(directed.size(), mk(OP_ADD, 1, 3, 4, 0, 3, 4));
    directed.insert(directed.size(), mk(OP_ADD, 0, 1, 4, 1, 3, 4));
    directed.insert(directed.size(), mk(OP_MUL, 1, 2, 3, 0, 3, 4));
    directed.insert(directed.size(), mk(OP_DIV, 1, 2, 3, 1, 4, 9));
    directed.insert(directed.size(), mk(OP_ADD, 0, 5, 0, 0, 1, 1));
    directed.insert(directed.size(), mk(OP_MUL, 0, 5, 1, 0, 1, 0));
    directed.insert(directed.size(), mk(OP_DIV, 0, 5, 0, 0, 0, 1));
    directed.insert(directed.size(), mk(OP_DIV, 1, 7, 3, 1, 0, 5));
    directed.insert(directed.size(), mk(OP_MUL, 0, '1, 1, 0, '1, 1));
    directed.insert(directed.size(), mk(OP_MUL, 0, 1, '1, 0, 1, '1));
    directed.insert(directed.size(), mk(OP_ADD, 0, '1, 1, 0, '1, 1));
    directed.insert(directed.size(), mk(OP_SUB, 1, '1, '1, 0, '1, '1));
    directed.insert(directed.size(), mk(OP_ADD, 1, '1, '1, 1, '1, 32'hFFFF_FFFE));
    directed.insert(directed.size(), mk(OP_DIV, 0, '1, '1, 0, '1, '1));
    directed.insert(directed.size(), mk(OP_MUL, 1, 0, 7, 0, 9, 11));
    directed.insert(directed.size(), mk(OP_DIV, 0, 0, 3, 1, 5, 2));
    directed.insert(directed.size(), mk(OP_SUB, 0, 0, 1, 0, 0, 1));
    directed.insert(directed.size(), mk(OP_ADD, 0, 6, 8, 0, 10, 12));
    foreach (directed[i]) send(directed[i]);

    // Random bursts with gaps; some stretches run without gaps
    while (accepted < directed.size() + RANDOM_ITEMS) begin
      burst_free = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 20)) begin
        o.op    = rau_op_e'($urandom_range(0, 3));
        o.l_neg = $urandom_range(0, 1);
        o.r_neg = $urandom_range(0, 1);
        o.l_num = rand_mag(0);
        o.r_num = rand_mag(0);
        o.l_den = rand_mag(1);
        o.r_den = rand_mag(1);
        send(o);
      end
      idle_gap();
    end
    @(negedge clk_i);
    in_valid_i <= 0;

    // Drain
    while (sb.pending.size() != 0) @(posedge clk_i);
    waited = 0;
    while (waited < DRAIN_CYCLES) begin
      @(posedge clk_i);
      waited++;
    end
    if (mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
